// ----- src/pfba_pkg.sv -----
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, constants and helpers of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int WORD_BITS      = 32;
	localparam int WBIT_W         = $clog2(WORD_BITS);
	localparam int FRAME_W        = 12;
	localparam int FIU_W          = 13;
	localparam int NUM_FRAMES_DEF = 4096;
	// upper bound on the word count that frames_in_use can reach
	localparam int SCAN_WORDS_MAX = (1 << FIU_W) / WORD_BITS;
	localparam int LIM_W          = $clog2(SCAN_WORDS_MAX) + 1;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [FIU_W-1:0]     FIU_RESET = FIU_W'(4096);
	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [2:0] {
		STAT_ALLOCATED = 3'd0,
		STAT_MAPPED    = 3'd1,
		STAT_EXHAUSTED = 3'd2,
		STAT_FREED     = 3'd3,
		STAT_NOTHING   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_MAPPED = 2'd2,
		CMD_NOFREE = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [FRAME_W-1:0] frame;
		logic               writable;
		logic               kernel;
	} cmd_t;

	// index of the lowest set bit, 0 when none is set
	function automatic logic [WBIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [WBIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = WBIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- src/pfba_ifs.sv -----
// ----------------------------------------------------------------------------
// pfba_ifs
// Valid/ready channels of the allocator: request, response and configuration.
// ----------------------------------------------------------------------------
interface pfba_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [pfba_pkg::FRAME_W-1:0] page_frame;
	logic                        kernel_page;
	logic                        writable;

	modport source (output valid, req_type, page_frame, kernel_page, writable, input ready);
	modport sink   (input valid, req_type, page_frame, kernel_page, writable, output ready);
endinterface

interface pfba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pfba_pkg::FRAME_W-1:0] frame_number;
	logic                        present_bit;
	logic                        rw_bit;
	logic                        user_bit;
	logic [2:0]                  status;

	modport source (output valid, frame_number, present_bit, rw_bit, user_bit, status,
		input ready);
	modport sink   (input valid, frame_number, present_bit, rw_bit, user_bit, status,
		output ready);
endinterface

interface pfba_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [pfba_pkg::FIU_W-1:0] frames_in_use;

	modport source (output valid, frames_in_use, input ready);
	modport sink   (input valid, frames_in_use, output ready);
endinterface

// ----- src/page_frame_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit page frame allocator over a bitmap of 32-frame words.
//
//   channel  role   payload
//   cfg      sink   frames_in_use (13 bits), always ready
//   req      sink   req_type, page_frame, kernel_page, writable
//   rsp      source frame_number, present_bit, rw_bit, user_bit, status
//
// allocate: the command is dequeued, then the full-word summary is scanned
// 32 words per cycle until a word with a free frame is found or the search
// range ends; a hit then gets a bitmap read-modify-write, as does a free.
// already-mapped and nothing-to-free answer without touching the bitmap.
// reset clears the summary and word valid flags, so all frames read as free.
// a two-entry command queue takes items while rsp stalls, until it is full.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator #(
	parameter int NUM_FRAMES = pfba_pkg::NUM_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pfba_cfg_if.sink    cfg,
	pfba_req_if.sink    req,
	pfba_rsp_if.source  rsp
);
	import pfba_pkg::*;

	logic [FIU_W-1:0] fiu_q;
	logic             push;
	cmd_t             push_cmd;
	logic             q_full;
	logic             pop;
	logic             q_valid;
	cmd_t             q_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
		end else if (cfg.valid) begin
			fiu_q <= cfg.frames_in_use;
		end
	end

	pfba_front u_front (
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pfba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	pfba_back #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frames_in_use (fiu_q),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.pop           (pop),
		.rsp           (rsp)
	);

endmodule

// ----- src/pfba_front.sv -----
// ----------------------------------------------------------------------------
// pfba_front
// Accepts request items and sorts them into commands for the back end.
// ----------------------------------------------------------------------------
module pfba_front (
	pfba_req_if.sink         req,
	input  logic             q_full,
	output logic             push,
	output pfba_pkg::cmd_t   push_cmd
);
	import pfba_pkg::*;

	logic frame_zero;

	assign frame_zero = (req.page_frame == '0);
	assign req.ready  = !q_full;
	assign push       = req.valid && !q_full;

	always_comb begin
		push_cmd.frame    = req.page_frame;
		push_cmd.writable = req.writable;
		push_cmd.kernel   = req.kernel_page;
		if (req.req_type == REQ_ALLOC) begin
			push_cmd.kind = frame_zero ? CMD_ALLOC : CMD_MAPPED;
		end else begin
			push_cmd.kind = frame_zero ? CMD_NOFREE : CMD_FREE;
		end
	end

endmodule

// ----- src/pfba_queue.sv -----
// ----------------------------------------------------------------------------
// pfba_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pfba_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfba_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           q_valid,
	output pfba_pkg::cmd_t q_cmd
);
	import pfba_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/pfba_back.sv -----
// ----------------------------------------------------------------------------
// pfba_back
// Carries out commands: full-word summary scan, bitmap read-modify-write,
// and the response register.
// ----------------------------------------------------------------------------
module pfba_back #(
	parameter int NUM_FRAMES = pfba_pkg::NUM_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pfba_pkg::FIU_W-1:0]  frames_in_use,
	input  logic                        q_valid,
	input  pfba_pkg::cmd_t              q_cmd,
	output logic                        pop,
	pfba_rsp_if.source                  rsp
);
	import pfba_pkg::*;

	localparam int NUM_WORDS  = NUM_FRAMES / WORD_BITS;
	// words above the reachable search range are never read back
	localparam int MEM_WORDS  = (NUM_WORDS < SCAN_WORDS_MAX) ? NUM_WORDS : SCAN_WORDS_MAX;
	localparam int MEM_AW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int NCHUNK     = (MEM_WORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int CW         = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int SCAN_SLOTS = NCHUNK * WORD_BITS;
	localparam int IDX_W      = FRAME_W - WBIT_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_READ  = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [WORD_BITS-1:0]   mem_q [MEM_WORDS];
	logic [MEM_WORDS-1:0]   word_vld_q;
	logic [MEM_WORDS-1:0]   full_q;
	logic [WORD_BITS-1:0]   rd_data_q;
	logic                   rd_vld_q;
	logic [MEM_AW-1:0]      addr_q;
	logic [WBIT_W-1:0]      bit_q;
	logic                   is_free_q;
	logic                   rw_q;
	logic                   user_q;
	logic [CW-1:0]          chunk_q;

	logic                   rsp_vld_q;
	logic [FRAME_W-1:0]     frame_q;
	logic                   present_q;
	logic                   rwbit_q;
	logic                   userbit_q;
	status_t                status_q;

	logic [LIM_W-1:0]       lim;
	logic [SCAN_SLOTS-1:0]  avail;
	logic [WORD_BITS-1:0]   chunk_avail;
	logic [WBIT_W-1:0]      chunk_pos;
	logic [MEM_AW-1:0]      found_word;
	logic [IDX_W-1:0]       free_idx;
	logic                   free_in_store;
	logic [WORD_BITS-1:0]   cur_word;
	logic [WBIT_W-1:0]      clr_pos;
	logic [WBIT_W-1:0]      mod_pos;
	logic [WORD_BITS-1:0]   new_word;
	logic                   slot_free;

	// searchable words: frames_in_use / 32, capped by the store
	always_comb begin
		logic [LIM_W-1:0] fw;
		fw  = LIM_W'(frames_in_use >> WBIT_W);
		lim = (fw > LIM_W'(MEM_WORDS)) ? LIM_W'(MEM_WORDS) : fw;
	end

	for (genvar g = 0; g < SCAN_SLOTS; g++) begin : g_avail
		if (g < MEM_WORDS) begin : g_real
			assign avail[g] = !full_q[g] && (LIM_W'(g) < lim);
		end else begin : g_pad
			assign avail[g] = 1'b0;
		end
	end

	assign chunk_avail = avail[chunk_q * WORD_BITS +: WORD_BITS];
	assign chunk_pos   = lowest_set(chunk_avail);
	assign found_word  = MEM_AW'({chunk_q, chunk_pos});

	assign free_idx      = q_cmd.frame[FRAME_W-1:WBIT_W];
	assign free_in_store = ((LIM_W + 1)'(free_idx) < (LIM_W + 1)'(MEM_WORDS));

	assign cur_word = rd_vld_q ? rd_data_q : '0;
	assign clr_pos  = lowest_set(~cur_word);
	assign mod_pos  = is_free_q ? bit_q : clr_pos;
	assign new_word = is_free_q ? (cur_word & ~(WORD_BITS'(1) << mod_pos))
	                            : (cur_word | (WORD_BITS'(1) << mod_pos));

	assign slot_free = !rsp_vld_q || rsp.ready;
	assign pop       = (state_q == S_IDLE) && q_valid && slot_free;

	assign rsp.valid        = rsp_vld_q;
	assign rsp.frame_number = frame_q;
	assign rsp.present_bit  = present_q;
	assign rsp.rw_bit       = rwbit_q;
	assign rsp.user_bit     = userbit_q;
	assign rsp.status       = status_q;

	// bitmap store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_data_q <= mem_q[addr_q];
			rd_vld_q  <= word_vld_q[addr_q];
		end
		if (state_q == S_WRITE) begin
			mem_q[addr_q] <= new_word;
		end
	end

	// command payload captured on pop; the scan loads the found word address
	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q    <= MEM_AW'(free_idx);
			bit_q     <= q_cmd.frame[WBIT_W-1:0];
			is_free_q <= (q_cmd.kind == CMD_FREE);
			rw_q      <= q_cmd.writable;
			user_q    <= !q_cmd.kernel;
		end else if (state_q == S_SCAN && chunk_avail != '0) begin
			addr_q <= found_word;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			present_q <= 1'b0;
			rwbit_q   <= 1'b0;
			userbit_q <= 1'b0;
			frame_q   <= '0;
			case (q_cmd.kind)
				CMD_MAPPED: begin
					frame_q  <= q_cmd.frame;
					status_q <= STAT_MAPPED;
				end
				CMD_NOFREE: status_q <= STAT_NOTHING;
				default:    status_q <= STAT_FREED;
			endcase
		end else if (state_q == S_SCAN && chunk_avail == '0) begin
			status_q <= STAT_EXHAUSTED;
		end else if (state_q == S_WRITE) begin
			if (is_free_q) begin
				status_q <= STAT_FREED;
			end else begin
				frame_q   <= FRAME_W'({addr_q, clr_pos});
				present_q <= 1'b1;
				rwbit_q   <= rw_q;
				userbit_q <= user_q;
				status_q  <= STAT_ALLOCATED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			chunk_q    <= '0;
			rsp_vld_q  <= 1'b0;
			word_vld_q <= '0;
			full_q     <= '0;
		end else begin
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (q_cmd.kind)
							CMD_ALLOC: begin
								chunk_q <= '0;
								state_q <= S_SCAN;
							end
							CMD_FREE: begin
								if (free_in_store) begin
									state_q <= S_READ;
								end else begin
									rsp_vld_q <= 1'b1;
								end
							end
							default: rsp_vld_q <= 1'b1;
						endcase
					end
				end
				S_SCAN: begin
					if (chunk_avail != '0) begin
						state_q <= S_READ;
					end else if (chunk_q == CW'(NCHUNK - 1)) begin
						rsp_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_READ: state_q <= S_WRITE;
				S_WRITE: begin
					word_vld_q[addr_q] <= 1'b1;
					full_q[addr_q]     <= (new_word == FULL_WORD);
					rsp_vld_q          <= 1'b1;
					state_q            <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- dv/page_frame_bitmap_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_tb
// Drives allocate and free requests into the frame allocator under several
// frames_in_use settings. Every response is checked against a bitmap
// predictor kept in the bench. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfba_pkg::*;

	localparam int MAP_WORDS      = NUM_FRAMES_DEF / WORD_BITS;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int QUIET_ITEMS    = 150;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               present;
		logic               rw;
		logic               user;
		status_t            status;
	} entry_update_t;

	logic clk = 1'b0;
	logic arst_n;

	pfba_cfg_if cfg_ch ();
	pfba_req_if req_ch ();
	pfba_rsp_if rsp_ch ();

	page_frame_bitmap_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state
	logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
	logic [FIU_W-1:0]     managed_frames;

	entry_update_t      expected_entries [$];
	entry_update_t      last_expected;
	entry_update_t      head_entry;
	logic [FRAME_W-1:0] owned_frames [$];

	logic src_idle_on;
	logic rsp_stall_on;
	int   errors;
	int   sent_count;
	int   cfg_writes;
	int   status_count [5];
	int   quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic entry_update_t predict_page_entry(input logic kind,
			input logic [FRAME_W-1:0] pf, input logic kern, input logic wr);
		entry_update_t r;
		int            limit;
		int            words;
		int            bitpos;
		logic          found;
		r = '0;
		r.status = STAT_NOTHING;
		if (kind == REQ_ALLOC) begin
			if (pf != '0) begin
				r.frame = pf;
				r.status = STAT_MAPPED;
			end else begin
				limit = (managed_frames > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : int'(managed_frames);
				words = limit / WORD_BITS;
				found = 1'b0;
				r.status = STAT_EXHAUSTED;
				// first word that is not full, lowest clear bit in it
				for (int w = 0; w < words && w < MAP_WORDS; w++) begin
					if (!found && frame_map[w] != FULL_WORD) begin
						bitpos = 0;
						while (frame_map[w][bitpos]) bitpos++;
						frame_map[w][bitpos] = 1'b1;
						found = 1'b1;
						r.frame = FRAME_W'(w * WORD_BITS + bitpos);
						r.present = 1'b1;
						r.rw = wr;
						r.user = ~kern;
						r.status = STAT_ALLOCATED;
					end
				end
			end
		end else if (pf != '0) begin
			frame_map[pf / WORD_BITS][pf % WORD_BITS] = 1'b0;
			r.status = STAT_FREED;
		end
		status_count[int'(r.status)]++;
		return r;
	endfunction

	task automatic send_request(input logic kind, input logic [FRAME_W-1:0] pf,
			input logic kern, input logic wr);
		entry_update_t exp_entry;
		@(negedge clk);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.page_frame  <= pf;
		req_ch.kernel_page <= kern;
		req_ch.writable    <= wr;
		do @(posedge clk); while (!req_ch.ready);
		exp_entry = predict_page_entry(kind, pf, kern, wr);
		expected_entries.push_back(exp_entry);
		last_expected = exp_entry;
		// frame 0 can never be handed back, so it is not tracked
		if (exp_entry.status == STAT_ALLOCATED && exp_entry.frame != '0) begin
			owned_frames.push_back(exp_entry.frame);
		end
		sent_count++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_frames_in_use(input logic [FIU_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.frames_in_use <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		managed_frames = value;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_directed_cases();
		// frame 0 comes first after reset, flag combinations on the next ones
		send_request(REQ_ALLOC, '0, 1'b0, 1'b1);
		send_request(REQ_ALLOC, '0, 1'b1, 1'b0);
		send_request(REQ_ALLOC, '0, 1'b1, 1'b1);
		send_request(REQ_ALLOC, '0, 1'b0, 1'b0);
		// page already holds a frame
		send_request(REQ_ALLOC, {FRAME_W{1'b1}}, 1'b0, 1'b1);
		send_request(REQ_ALLOC, FRAME_W'(1), 1'b1, 1'b1);
		send_request(REQ_ALLOC, FRAME_W'('h555), 1'b0, 1'b0);
		// free of a page without a frame
		send_request(REQ_FREE, '0, 1'b1, 1'b1);
		send_request(REQ_FREE, '0, 1'b0, 1'b0);
		// free then reuse of the hole
		send_request(REQ_FREE, FRAME_W'(2), 1'b0, 1'b1);
		send_request(REQ_ALLOC, '0, 1'b0, 1'b1);
		send_request(REQ_FREE, FRAME_W'(1), 1'b1, 1'b0);
		send_request(REQ_FREE, FRAME_W'(3), 1'b0, 1'b0);
		send_request(REQ_ALLOC, '0, 1'b1, 1'b1);
		send_request(REQ_ALLOC, '0, 1'b0, 1'b0);
		// frees of frames never handed out, top frame included
		send_request(REQ_FREE, {FRAME_W{1'b1}}, 1'b1, 1'b1);
		send_request(REQ_FREE, FRAME_W'('hAAA), 1'b0, 1'b1);
		send_request(REQ_FREE, FRAME_W'('h555), 1'b1, 1'b0);
		send_request(REQ_ALLOC, '0, 1'b1, 1'b0);
	endtask

	task automatic test_exhaustion_and_limits();
		// one word managed: fill it up
		wait_idle();
		write_frames_in_use(FIU_W'(WORD_BITS));
		do begin
			send_request(REQ_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end while (last_expected.status != STAT_EXHAUSTED);
		send_request(REQ_ALLOC, '0, 1'b1, 1'b1);
		send_request(REQ_FREE, FRAME_W'(17), 1'b0, 1'b0);
		send_request(REQ_ALLOC, '0, 1'b0, 1'b1);
		send_request(REQ_ALLOC, '0, 1'b1, 1'b0);
		// frames of a trailing partial word are never handed out
		wait_idle();
		write_frames_in_use(FIU_W'(2 * WORD_BITS - 1));
		send_request(REQ_ALLOC, '0, 1'b0, 1'b1);
		// values above the store size search the whole bitmap
		wait_idle();
		write_frames_in_use({FIU_W{1'b1}});
		send_request(REQ_ALLOC, '0, 1'b1, 1'b1);
		send_request(REQ_ALLOC, '0, 1'b0, 1'b0);
		wait_idle();
		write_frames_in_use(FIU_RESET);
		send_request(REQ_ALLOC, '0, 1'b0, 1'b1);
	endtask

	task automatic test_random_traffic();
		int                 random_sent;
		int                 phase;
		int                 phase_len;
		int                 pick;
		int                 idx;
		logic               quiet;
		logic [FIU_W-1:0]   fiu;
		logic [FRAME_W-1:0] pf;
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			quiet = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
			case (phase)
				0: fiu = FIU_RESET;
				1: fiu = FIU_W'(3 * WORD_BITS);
				2: fiu = FIU_W'(WORD_BITS);
				3: fiu = {FIU_W{1'b1}};
				4: fiu = FIU_W'(200);
				default: fiu = FIU_W'($urandom_range(WORD_BITS, NUM_FRAMES_DEF));
			endcase
			wait_idle();
			write_frames_in_use(fiu);
			src_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
			rsp_stall_on = !quiet && ($urandom_range(0, 3) != 0);
			if (quiet) begin
				phase_len = RANDOM_ITEMS - random_sent;
			end else begin
				phase_len = $urandom_range(120, 260);
				if (random_sent + phase_len > RANDOM_ITEMS - QUIET_ITEMS) begin
					phase_len = RANDOM_ITEMS - QUIET_ITEMS - random_sent;
				end
			end
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					send_request(REQ_ALLOC, '0, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end else if (pick < 80 && owned_frames.size() != 0) begin
					// give back a frame the pages hold
					idx = $urandom_range(0, owned_frames.size() - 1);
					pf = owned_frames[idx];
					owned_frames.delete(idx);
					send_request(REQ_FREE, pf, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end else if (pick < 88) begin
					send_request(REQ_ALLOC, FRAME_W'($urandom_range(1, (1 << FRAME_W) - 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else if (pick < 93) begin
					send_request(REQ_FREE, '0, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end else begin
					send_request(REQ_FREE, FRAME_W'($urandom_range(1, (1 << FRAME_W) - 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
				random_sent++;
			end
			phase++;
		end
	endtask

	// response stalls in bursts
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_stall_on && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_entries.size() == 0) begin
				$error("response with nothing pending: frame_number %0d status %0d",
					rsp_ch.frame_number, rsp_ch.status);
				errors++;
			end else begin
				head_entry = expected_entries.pop_front();
				if (rsp_ch.frame_number !== head_entry.frame) begin
					$error("frame_number: expected %0d, got %0d", head_entry.frame,
						rsp_ch.frame_number);
					errors++;
				end
				if (rsp_ch.present_bit !== head_entry.present) begin
					$error("present_bit: expected %0b, got %0b", head_entry.present,
						rsp_ch.present_bit);
					errors++;
				end
				if (rsp_ch.rw_bit !== head_entry.rw) begin
					$error("rw_bit: expected %0b, got %0b", head_entry.rw, rsp_ch.rw_bit);
					errors++;
				end
				if (rsp_ch.user_bit !== head_entry.user) begin
					$error("user_bit: expected %0b, got %0b", head_entry.user, rsp_ch.user_bit);
					errors++;
				end
				if (rsp_ch.status !== head_entry.status) begin
					$error("status: expected %0d, got %0d", head_entry.status, rsp_ch.status);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d responses pending",
					quiet_cycles, expected_entries.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_ALLOC;
		req_ch.page_frame    = '0;
		req_ch.kernel_page   = 1'b0;
		req_ch.writable      = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.frames_in_use = FIU_RESET;
		src_idle_on          = 1'b1;
		rsp_stall_on         = 1'b1;
		errors               = 0;
		sent_count           = 0;
		cfg_writes           = 0;
		quiet_cycles         = 0;
		managed_frames       = FIU_RESET;
		for (int i = 0; i < MAP_WORDS; i++) frame_map[i] = '0;
		for (int i = 0; i < 5; i++) status_count[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_exhaustion_and_limits();
		test_random_traffic();

		wait_idle();
		if (expected_entries.size() != 0) begin
			$error("%0d responses never arrived", expected_entries.size());
			errors++;
		end
		$display("%0d requests over %0d frames_in_use settings", sent_count, cfg_writes);
		$display("allocated %0d, already mapped %0d, out of frames %0d, freed %0d, no frame %0d",
			status_count[int'(STAT_ALLOCATED)], status_count[int'(STAT_MAPPED)],
			status_count[int'(STAT_EXHAUSTED)], status_count[int'(STAT_FREED)],
			status_count[int'(STAT_NOTHING)]);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
